FILE: sv/sha1_message_hasher_core_defines.svh
// assertion macros of the sha-1 hasher rtl, used by the controller
`ifndef SHA1_MESSAGE_HASHER_CORE_DEFINES_SVH
`define SHA1_MESSAGE_HASHER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SHA1_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SHA1_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sha1_pkg.sv
// types, constants and round functions of the sha-1 hasher
`default_nettype none
package sha1_pkg;

    localparam int unsigned NUM_WORDS  = 5;
    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned BLOCK_BITS = 512;

    localparam logic [31:0] H_INIT [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    // 448 bits into the block, where the length field starts
    localparam logic [5:0] LEN_POS    = 6'(448 / 8);
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [6:0] ROUND_LAST = 7'(NUM_ROUNDS - 1);
    localparam logic [2:0] WORD_LAST  = 3'(NUM_WORDS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_PAD_80,
        S_PAD_ZERO,
        S_PAD_LEN,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PUSH_DATA,
        PUSH_80,
        PUSH_ZERO,
        PUSH_LEN
    } t_push_sel;

    typedef enum logic [1:0] {
        PH_CH,
        PH_PAR1,
        PH_MAJ,
        PH_PAR2
    } t_phase;

    typedef struct packed {
        logic      push;
        t_push_sel push_sel;
        logic      latch_len;
        logic      load_work;
        logic      round;
        t_phase    phase;
        logic      add_chain;
        logic      init;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] pos;
    } t_dp_sts;

    function automatic logic [31:0] round_f(input t_phase ph, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (ph)
            PH_CH:   f = (b & c) | (~b & d);
            PH_MAJ:  f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] round_k(input t_phase ph);
        logic [31:0] k;
        case (ph)
            PH_CH:   k = K_0;
            PH_PAR1: k = K_1;
            PH_MAJ:  k = K_2;
            default: k = K_3;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

FILE: sv/sha1_ifs.sv
// request channels of the sha-1 hasher: message bytes in, digest words out
`default_nettype none
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input end_of_message, output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface
`default_nettype wire

FILE: sv/sha1_message_hasher_core.sv
// top level of the sha-1 message hasher: controller and datapath joined to the channels
`default_nettype none
// SHA-1 (RFC 3174) hasher taking the message one byte per request on i_msg. A request
// with has_byte low carries no byte, so a lone end_of_message request hashes the empty
// message. Ordinary bytes are taken one per cycle: each byte shifts straight into a
// 512-bit message schedule line. The 64th byte of a block starts a compression (a load
// step, 80 rounds through a single round unit, an add step into the chaining words)
// during which no request is taken. On end_of_message the block pads with 0x80, zeros
// up to byte 56 and the big-endian 64-bit bit count (it wraps modulo 2^64), one byte
// per cycle between compressions plus a step with no push on reaching byte 56; the
// padding takes one or two compressions. The digest then leaves on o_digest as five
// 32-bit words, H0 first, word_index 0 to 4 and last_word set on the fifth; no new
// message byte is taken until all five have been accepted. After the fifth word the
// chaining words and the bit count return to their initial values for the next message.
module sha1_message_hasher_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sha1_in_if.sink    i_msg,
    sha1_out_if.source o_digest
);
    import sha1_pkg::*;

    t_dp_cmd     cmd;
    t_dp_sts     sts;
    logic [2:0]  word_index;
    logic [31:0] digest_word;

    // sequencing: intake, padding, round count and word output
    sha1_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_msg.valid),
        .o_in_ready       (i_msg.ready),
        .i_has_byte       (i_msg.has_byte),
        .i_end_of_message (i_msg.end_of_message),
        .o_out_valid      (o_digest.valid),
        .i_out_ready      (o_digest.ready),
        .o_word_index     (word_index),
        .o_last_word      (o_digest.last_word),
        .o_cmd            (cmd),
        .i_sts            (sts)
    );

    // schedule line, round unit, chaining words and length counter
    sha1_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_msg.data_byte),
        .i_word_index  (word_index),
        .o_sts         (sts),
        .o_digest_word (digest_word)
    );

    // digest words come straight from the chaining registers, held while waiting
    assign o_digest.digest_word = digest_word;
    assign o_digest.word_index  = word_index;

endmodule
`default_nettype wire

FILE: sv/sha1_datapath.sv
// sha-1 datapath: message schedule shift line, round unit, chaining words, length
`default_nettype none
module sha1_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sha1_pkg::t_dp_cmd i_cmd,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic [2:0]       i_word_index,
    output sha1_pkg::t_dp_sts     o_sts,
    output logic [31:0]           o_digest_word
);
    import sha1_pkg::*;

    localparam int unsigned BW = BLOCK_BITS;

    logic [BW-1:0] r_w;
    logic [31:0]   r_a, r_b, r_c, r_d, r_e;
    logic [31:0]   r_h [NUM_WORDS];
    logic [63:0]   r_bits;
    logic [63:0]   r_len;

    logic [7:0]    push_byte;
    logic [31:0]   w0, w2, w8, w13, w_new, t_sum;

    // word j of the 16-word window sits at the top minus 32*j
    assign w0  = r_w[BW-1        -: 32];
    assign w2  = r_w[BW-1-32*2   -: 32];
    assign w8  = r_w[BW-1-32*8   -: 32];
    assign w13 = r_w[BW-1-32*13  -: 32];

    always_comb begin
        logic [31:0] x;
        x     = w13 ^ w8 ^ w2 ^ w0;
        w_new = {x[30:0], x[31]};
        t_sum = {r_a[26:0], r_a[31:27]} + round_f(i_cmd.phase, r_b, r_c, r_d)
              + r_e + round_k(i_cmd.phase) + w0;
    end

    always_comb begin
        case (i_cmd.push_sel)
            PUSH_DATA: push_byte = i_data_byte;
            PUSH_80:   push_byte = PAD_BYTE;
            PUSH_ZERO: push_byte = 8'h00;
            PUSH_LEN:  push_byte = r_len[63:56];
            default:   push_byte = 8'h00;
        endcase
    end

    // schedule window and working variables carry no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_w <= {r_w[BW-9:0], push_byte};
        end else if (i_cmd.round) begin
            r_w <= {r_w[BW-33:0], w_new};
        end
        if (i_cmd.load_work) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round) begin
            r_a <= t_sum;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
        if (i_cmd.latch_len) begin
            r_len <= r_bits + (i_cmd.push ? 64'd8 : 64'd0);
        end else if (i_cmd.push && i_cmd.push_sel == PUSH_LEN) begin
            r_len <= {r_len[55:0], 8'h00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h    <= H_INIT;
            r_bits <= 64'd0;
        end else begin
            if (i_cmd.init) begin
                r_h    <= H_INIT;
                r_bits <= 64'd0;
            end else begin
                if (i_cmd.add_chain) begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                end
                if (i_cmd.push) begin
                    r_bits <= r_bits + 64'd8;
                end
            end
        end
    end

    assign o_sts.pos     = r_bits[8:3];
    assign o_digest_word = r_h[i_word_index];

endmodule
`default_nettype wire

FILE: sv/sha1_ctrl.sv
// sha-1 controller: byte intake, padding sequence, round count, digest output
`default_nettype none
`include "sha1_message_hasher_core_defines.svh"
module sha1_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_has_byte,
    input  wire logic             i_end_of_message,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [2:0]            o_word_index,
    output logic                  o_last_word,
    output sha1_pkg::t_dp_cmd     o_cmd,
    input  wire sha1_pkg::t_dp_sts i_sts
);
    import sha1_pkg::*;

    t_state     r_state, n_state;
    t_state     r_ret, n_ret;
    logic [6:0] r_round, n_round;
    logic [2:0] r_word, n_word;

    logic       in_acc, out_acc, at_last;

    assign at_last = (i_sts.pos == BLOCK_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_round <= 7'd0;
            r_word  <= 3'd0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_round <= n_round;
            r_word  <= n_word;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_round     = r_round;
        n_word      = r_word;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        in_acc      = 1'b0;
        out_acc     = 1'b0;

        if (r_round < 7'd20) begin
            o_cmd.phase = PH_CH;
        end else if (r_round < 7'd40) begin
            o_cmd.phase = PH_PAR1;
        end else if (r_round < 7'd60) begin
            o_cmd.phase = PH_MAJ;
        end else begin
            o_cmd.phase = PH_PAR2;
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                in_acc     = i_in_valid;
                if (in_acc) begin
                    o_cmd.push      = i_has_byte;
                    o_cmd.push_sel  = PUSH_DATA;
                    o_cmd.latch_len = i_end_of_message;
                    if (i_has_byte && at_last) begin
                        n_state = S_LOAD;
                        n_ret   = i_end_of_message ? S_PAD_80 : S_IDLE;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD_80;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load_work = 1'b1;
                n_round         = 7'd0;
                n_state         = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (r_round == ROUND_LAST) begin
                    n_state = S_ADD;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            S_ADD: begin
                o_cmd.add_chain = 1'b1;
                n_state         = r_ret;
            end
            S_PAD_80: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = PUSH_80;
                n_state        = at_last ? S_LOAD : S_PAD_ZERO;
                n_ret          = S_PAD_ZERO;
            end
            S_PAD_ZERO: begin
                if (i_sts.pos == LEN_POS) begin
                    n_state = S_PAD_LEN;
                end else begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_sel = PUSH_ZERO;
                    if (at_last) begin
                        n_state = S_LOAD;
                        n_ret   = S_PAD_ZERO;
                    end
                end
            end
            S_PAD_LEN: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = PUSH_LEN;
                n_word         = 3'd0;
                if (at_last) begin
                    n_state = S_LOAD;
                    n_ret   = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                out_acc     = i_out_ready;
                if (out_acc) begin
                    if (r_word == WORD_LAST) begin
                        o_cmd.init = 1'b1;
                        n_word     = 3'd0;
                        n_state    = S_IDLE;
                    end else begin
                        n_word = r_word + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_word_index = r_word;
    assign o_last_word  = (r_word == WORD_LAST);

    `SHA1_ASSERT_NOW(a_round_range, i_clk, i_rst_n, 1'b1, r_round <= ROUND_LAST, "round count out of range")
    `SHA1_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready, "input taken while digest pending")
    `SHA1_ASSERT_NEXT(a_back_idle, i_clk, i_rst_n, out_acc && o_last_word, r_state == S_IDLE && r_word == 3'd0, "no return to idle after last word")
    `SHA1_ASSERT_NEXT(a_load_round, i_clk, i_rst_n, o_cmd.load_work, r_state == S_ROUND && r_round == 7'd0, "rounds did not start after load")

endmodule
`default_nettype wire

FILE: verif/tb_sha1_message_hasher_core.sv
// testbench of the sha-1 message hasher: directed and random messages checked against a digest predictor
module tb_sha1_message_hasher_core;

    // one digest word as the output channel carries it
    typedef struct {
        bit [31:0] digest_word;
        bit [2:0]  word_index;
        bit        last_word;
    } digest_entry_t;

    // sha-1 digest predictor plus the queue of digest words still owed by the block
    class sha1_digest_tracker;
        bit [31:0]     chain [5];
        bit [7:0]      block_bytes [64];
        bit [63:0]     bit_count;
        digest_entry_t pending_words [$];
        int unsigned   mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        // initial chaining words and zero length
        function void restart();
            chain[0] = 32'h67452301;
            chain[1] = 32'hEFCDAB89;
            chain[2] = 32'h98BADCFE;
            chain[3] = 32'h10325476;
            chain[4] = 32'hC3D2E1F0;
            bit_count = '0;
        endfunction

        function bit [31:0] rotl(bit [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        // 80 rounds over the filled block, folded into the chaining words
        function void compress();
            bit [31:0] w [80];
            bit [31:0] a, b, c, d, e, f, k, t;
            for (int i = 0; i < 16; i++)
                w[i] = {block_bytes[4*i], block_bytes[4*i+1],
                        block_bytes[4*i+2], block_bytes[4*i+3]};
            for (int i = 16; i < 80; i++)
                w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
            for (int i = 0; i < 80; i++) begin
                if (i < 20) begin
                    f = (b & c) | (~b & d);
                    k = 32'h5A827999;
                end else if (i < 40) begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9EBA1;
                end else if (i < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8F1BBCDC;
                end else begin
                    f = b ^ c ^ d;
                    k = 32'hCA62C1D6;
                end
                t = rotl(a, 5) + f + e + k + w[i];
                e = d; d = c; c = rotl(b, 30); b = a; a = t;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
        endfunction

        function void absorb(bit [7:0] v);
            bit [5:0] pos;
            pos = bit_count[8:3];
            block_bytes[pos] = v;
            bit_count += 64'd8;
            if (pos == 6'd63)
                compress();
        endfunction

        // an accepted request: append its byte, and on end of message pad and queue the digest
        function void take_request(bit [7:0] data_byte, bit has_byte, bit end_of_message);
            bit [63:0]     msg_len;
            digest_entry_t entry;
            if (has_byte)
                absorb(data_byte);
            if (!end_of_message)
                return;
            msg_len = bit_count;
            absorb(8'h80);
            while (bit_count[8:3] != 6'd56)
                absorb(8'h00);
            for (int i = 0; i < 8; i++)
                absorb(msg_len[63 - 8*i -: 8]);
            for (int i = 0; i < 5; i++) begin
                entry.digest_word = chain[i];
                entry.word_index  = 3'(i);
                entry.last_word   = (i == 4);
                pending_words.push_back(entry);
            end
            restart();
        endfunction

        function void check_word(bit [31:0] digest_word, bit [2:0] word_index, bit last_word);
            digest_entry_t want;
            if (pending_words.size() == 0) begin
                $error("digest_word: nothing expected, got %h", digest_word);
                mismatches++;
                return;
            end
            want = pending_words.pop_front();
            if (digest_word !== want.digest_word) begin
                $error("digest_word: expected %h, got %h", want.digest_word, digest_word);
                mismatches++;
            end
            if (word_index !== want.word_index) begin
                $error("word_index: expected %0d, got %0d", want.word_index, word_index);
                mismatches++;
            end
            if (last_word !== want.last_word) begin
                $error("last_word: expected %0d, got %0d", want.last_word, last_word);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sha1_in_if  msg_if ();
    sha1_out_if digest_if ();

    sha1_message_hasher_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_msg    (msg_if),
        .o_digest (digest_if)
    );

    sha1_digest_tracker tracker = new();

    // no idling on either side while set
    bit calm = 1'b0;
    int items_sent = 0;

    // block lengths around the padding and block boundaries
    int boundary_lengths [4] = '{55, 56, 63, 64};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10000000;
        $display("sha1_message_hasher_core verification failed");
        $finish;
    end

    // digest sink: random back pressure
    initial begin
        digest_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            digest_if.ready = calm || ($urandom_range(99) >= 26);
        end
    end

    // digest monitor
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && digest_if.valid && digest_if.ready)
                tracker.check_word(digest_if.digest_word, digest_if.word_index,
                                   digest_if.last_word);
        end
    end

    function automatic bit [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // one request on the message channel; called and left at a falling edge
    task automatic send_request(bit [7:0] data_byte, bit has_byte, bit end_of_message);
        while (!calm && $urandom_range(99) < 26) begin
            msg_if.valid = 1'b0;
            @(negedge i_clk);
        end
        msg_if.valid          = 1'b1;
        msg_if.data_byte      = data_byte;
        msg_if.has_byte       = has_byte;
        msg_if.end_of_message = end_of_message;
        do @(posedge i_clk); while (!msg_if.ready);
        tracker.take_request(data_byte, has_byte, end_of_message);
        items_sent++;
        @(negedge i_clk);
    endtask

    // random message of the given length, sometimes with empty requests mixed in;
    // ends either on its last byte or on a separate request with no byte
    task automatic send_message(int len);
        bit ends_bare;
        ends_bare = (len == 0) || ($urandom_range(3) == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0)
                send_request(pick_byte(), 1'b0, 1'b0);
            send_request(pick_byte(), 1'b1, (i == len - 1) && !ends_bare);
        end
        if (ends_bare)
            send_request(pick_byte(), 1'b0, 1'b1);
    endtask

    initial begin
        int msg_count;
        i_rst_n               = 1'b0;
        msg_if.valid          = 1'b0;
        msg_if.data_byte      = '0;
        msg_if.has_byte       = 1'b0;
        msg_if.end_of_message = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // empty message straight after reset
        send_request(8'h00, 1'b0, 1'b1);
        // "abc", end on the last byte
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        // empty request between messages changes nothing
        send_request(8'hFF, 1'b0, 1'b0);
        // extreme bytes with an empty request inside, ended by a request with no byte
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'h5A, 1'b0, 1'b0);
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'hA5, 1'b0, 1'b1);
        // single byte carrying the end flag
        send_request(8'hFF, 1'b1, 1'b1);
        // two empty messages back to back
        send_request(8'hFF, 1'b0, 1'b1);
        send_request(8'h00, 1'b0, 1'b1);

        // random messages: mostly short, every third one at a block boundary length
        msg_count = 0;
        while (items_sent < 350 || msg_count < 14) begin
            calm = (msg_count >= 6 && msg_count <= 8);
            if (msg_count % 3 == 2)
                send_message(boundary_lengths[(msg_count / 3) % 4]);
            else
                send_message($urandom_range(24));
            // stray empty request now and then
            if ($urandom_range(3) == 0)
                send_request(pick_byte(), 1'b0, 1'b0);
            msg_count++;
        end
        calm = 1'b0;
        msg_if.valid = 1'b0;

        // drain, then watch a while for anything extra
        while (tracker.pending_words.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.pending_words.size() == 0)
            $display("sha1_message_hasher_core verification clean");
        else
            $display("sha1_message_hasher_core verification failed");
        $finish;
    end

endmodule
